// ===== design/smhpp_pkg.sv =====
// ----------------------------------------------------------------------------
// smhpp_pkg: shared types and constants of the spectrum max-hold peak pool
// Item formats, register indexes, the hold store entry format and the
// fixed widths of the item fields.
// ----------------------------------------------------------------------------
`default_nettype none

package smhpp_pkg;

   // Fixed field widths.
   localparam int VALUE_W = 16;
   localparam int CFG_W   = 13;
   localparam int DISP_W  = 12;

   // Clear generation tag kept beside every hold store entry.
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = {{(EPOCH_W-1){1'b0}}, 1'b1};

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BINS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_BINS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXHOLD_ENABLE = 2'd2;

   localparam logic [CFG_W-1:0] FRAME_BINS_RESET   = 13'd4096;
   localparam logic [CFG_W-1:0] DISPLAY_BINS_RESET = 13'd1024;

   // Item operation codes.
   localparam logic OP_BIN   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic                      op;
      logic signed [VALUE_W-1:0] bin_value;
      logic                      bin_finite;
   } req_item_type;

   typedef struct packed {
      logic [DISP_W-1:0]         display_index;
      logic signed [VALUE_W-1:0] live_peak;
      logic signed [VALUE_W-1:0] hold_peak;
      logic                      last;
   } rsp_item_type;

   typedef struct packed {
      logic [EPOCH_W-1:0]        tag;
      logic signed [VALUE_W-1:0] value;
   } hold_entry_type;

   // One bin on its way from the framing stage to the peak stage.
   typedef struct packed {
      logic                      en;
      logic                      finite;
      logic signed [VALUE_W-1:0] value;
      logic [EPOCH_W-1:0]        epoch;
      logic                      group_done;
      logic                      frame_done;
      logic [DISP_W-1:0]         shown;
      logic signed [VALUE_W-1:0] live;
   } stage_item_type;

endpackage

`default_nettype wire

// ===== design/smhpp_hold_ram.sv =====
// ----------------------------------------------------------------------------
// smhpp_hold_ram: max-hold store
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smhpp_hold_ram #(
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                    clock,
   input  wire logic                    rd_en,
   input  wire logic [AW-1:0]           rd_addr,
   output smhpp_pkg::hold_entry_type    rd_entry,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  smhpp_pkg::hold_entry_type    wr_entry
);
   import smhpp_pkg::*;

   hold_entry_type mem [DEPTH];
   hold_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/smhpp_framer.sv =====
// ----------------------------------------------------------------------------
// smhpp_framer: bin framing stage
// Tracks the bin position, display group boundaries and the live peak, and
// launches each bin towards the peak stage with its hold store read.
// ----------------------------------------------------------------------------
`default_nettype none

module smhpp_framer #(
   parameter int MAX_BINS = 4096,
   localparam int AW = $clog2(MAX_BINS),
   localparam int SW = $clog2(MAX_BINS + 1)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  restart,
   input  wire logic                                  accept,
   input  wire logic                                  adv,
   input  wire logic signed [smhpp_pkg::VALUE_W-1:0]  value,
   input  wire logic                                  finite,
   input  wire logic                                  en,
   input  wire logic [SW-1:0]                         f_eff,
   input  wire logic [SW-1:0]                         d_eff,
   input  wire logic [smhpp_pkg::EPOCH_W-1:0]         item_epoch,
   output logic [AW-1:0]                              rd_addr,
   output logic                                       size_clear,
   output logic                                       s1_valid,
   output smhpp_pkg::stage_item_type                  s1_item,
   output logic [AW-1:0]                              s1_addr
);
   import smhpp_pkg::*;

   localparam int DW = SW + 2;

   logic [AW-1:0]              cnt_ff, cnt_in;
   logic [AW-1:0]              group_ff, group_in;
   logic signed [DW-1:0]       delta_ff, delta_in;
   logic                       fresh_ff, fresh_in;
   logic signed [VALUE_W-1:0]  live_ff, live_in;
   logic [SW-1:0]              held_ff, held_in;
   logic                       s1_valid_ff, s1_valid_in;
   stage_item_type             s1_item_ff, s1_item_in;
   logic [AW-1:0]              s1_addr_ff, s1_addr_in;

   logic                       pool;
   logic                       frame_done;
   logic                       group_done;
   logic signed [DW-1:0]       delta_base;
   logic signed [DW-1:0]       delta_check;
   logic signed [VALUE_W-1:0]  live_new;
   logic [DISP_W-1:0]          shown;

   // The group test keeps (idx+1)*d - (g+1)*f as a running difference; the
   // group closes once adding d makes it positive.
   always_comb begin
      pool        = f_eff > d_eff;
      frame_done  = (SW'(cnt_ff) + SW'(1)) == f_eff;
      delta_base  = fresh_ff ? (DW'(d_eff) - DW'(f_eff)) : delta_ff;
      delta_check = delta_base + DW'(d_eff);
      group_done  = !pool || frame_done ||
                    (!delta_check[DW-1] && (delta_check != '0));
      live_new    = ($signed(value) > $signed(live_ff)) ? value : live_ff;
      shown       = pool ? DISP_W'(group_ff) : DISP_W'(cnt_ff);
      size_clear  = accept && en && (held_ff != f_eff);
   end

   always_comb begin
      cnt_in      = cnt_ff;
      group_in    = group_ff;
      delta_in    = delta_ff;
      fresh_in    = fresh_ff;
      live_in     = live_ff;
      held_in     = held_ff;
      s1_item_in  = s1_item_ff;
      s1_addr_in  = s1_addr_ff;
      s1_valid_in = adv ? 1'b0 : s1_valid_ff;

      if (restart) begin
         cnt_in   = '0;
         group_in = '0;
         fresh_in = 1'b1;
         live_in  = VALUE_MIN;
      end else if (accept) begin
         s1_valid_in           = 1'b1;
         s1_addr_in            = cnt_ff;
         s1_item_in.en         = en;
         s1_item_in.finite     = finite;
         s1_item_in.value      = value;
         s1_item_in.epoch      = item_epoch;
         s1_item_in.group_done = group_done;
         s1_item_in.frame_done = frame_done;
         s1_item_in.shown      = shown;
         s1_item_in.live       = live_new;
         if (en) begin
            held_in = f_eff;
         end
         if (frame_done) begin
            cnt_in   = '0;
            group_in = '0;
            fresh_in = 1'b1;
            live_in  = VALUE_MIN;
         end else begin
            cnt_in   = cnt_ff + AW'(1);
            fresh_in = 1'b0;
            if (group_done) begin
               live_in  = VALUE_MIN;
               group_in = group_ff + AW'(1);
               if (pool) begin
                  delta_in = delta_check - DW'(f_eff);
               end
            end else begin
               live_in = live_new;
               if (pool) begin
                  delta_in = delta_check;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         group_ff    <= '0;
         fresh_ff    <= 1'b1;
         live_ff     <= VALUE_MIN;
         held_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         group_ff    <= group_in;
         fresh_ff    <= fresh_in;
         live_ff     <= live_in;
         held_ff     <= held_in;
         s1_valid_ff <= s1_valid_in;
      end
      delta_ff   <= delta_in;
      s1_item_ff <= s1_item_in;
      s1_addr_ff <= s1_addr_in;
   end

   assign rd_addr  = cnt_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;
   assign s1_addr  = s1_addr_ff;

   // The bin position always lies inside the current frame.
   a_cnt_in_frame: assert property (@(posedge clock) disable iff (reset)
      SW'(cnt_ff) < f_eff)
      else $error("bin position outside the frame");

endmodule

`default_nettype wire

// ===== design/smhpp_scrubber.sv =====
// ----------------------------------------------------------------------------
// smhpp_scrubber: clear generation keeper and store sweeper
// Hands out the clear generation for new bins and, when the generation count
// runs out or after reset, sweeps the hold store to rebase its tags.
// ----------------------------------------------------------------------------
`default_nettype none

module smhpp_scrubber #(
   parameter int MAX_BINS = 4096,
   localparam int AW = $clog2(MAX_BINS)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear_req,
   input  wire logic                          start_ok,
   input  smhpp_pkg::hold_entry_type          rd_entry,
   output logic [smhpp_pkg::EPOCH_W-1:0]      epoch_cur,
   output logic                               busy,
   output logic                               rd_en,
   output logic [AW-1:0]                      rd_addr,
   output logic                               wr_en,
   output logic [AW-1:0]                      wr_addr,
   output smhpp_pkg::hold_entry_type          wr_entry
);
   import smhpp_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               init_ff, init_in;

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      epoch_in   = epoch_ff;
      init_in    = init_ff;
      rd_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (clear_req) begin
               epoch_in = epoch_ff + EPOCH_W'(1);
            end
            if ((epoch_ff == EPOCH_MAX) && start_ok) begin
               state_in = ST_SCAN;
               addr_in  = '0;
            end
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            wr_pend_in = 1'b1;
            wr_addr_in = addr_ff;
            addr_in    = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
            epoch_in = EPOCH_FIRST;
            init_in  = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SCAN;
         addr_ff    <= '0;
         wr_pend_ff <= 1'b0;
         epoch_ff   <= EPOCH_MAX;
         init_ff    <= 1'b1;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         wr_pend_ff <= wr_pend_in;
         epoch_ff   <= epoch_in;
         init_ff    <= init_in;
      end
      wr_addr_ff <= wr_addr_in;
   end

   // Entries of the newest generation move to the first one; all others,
   // and everything on the pass after reset, become invalid.
   always_comb begin
      wr_entry.value = rd_entry.value;
      wr_entry.tag   = (!init_ff && (rd_entry.tag == EPOCH_MAX)) ? EPOCH_FIRST : '0;
   end

   assign epoch_cur = clear_req ? (epoch_ff + EPOCH_W'(1)) : epoch_ff;
   assign busy      = (state_ff != ST_IDLE) || (epoch_ff == EPOCH_MAX);
   assign rd_addr   = addr_ff;
   assign wr_en     = wr_pend_ff;
   assign wr_addr   = wr_addr_ff;

   // Generation zero marks invalid entries and is never handed out.
   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("clear generation reached zero");

endmodule

`default_nettype wire

// ===== design/smhpp_peak_stage.sv =====
// ----------------------------------------------------------------------------
// smhpp_peak_stage: hold update and result stage
// Merges the hold store entry with the bin, writes it back, keeps the group
// hold peak and holds the result item until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module smhpp_peak_stage #(
   parameter int MAX_BINS = 4096,
   localparam int AW = $clog2(MAX_BINS)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     restart,
   input  wire logic                     accept,
   input  wire logic [AW-1:0]            rd_addr,
   input  wire logic                     s1_valid,
   input  smhpp_pkg::stage_item_type     s1_item,
   input  wire logic [AW-1:0]            s1_addr,
   input  smhpp_pkg::hold_entry_type     rd_entry,
   input  wire logic                     rsp_stall,
   output logic                          adv,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output smhpp_pkg::hold_entry_type     wr_entry,
   output logic                          rsp_valid,
   output smhpp_pkg::rsp_item_type       rsp_item
);
   import smhpp_pkg::*;

   logic                       fwd_hit_ff, fwd_hit_in;
   hold_entry_type             fwd_entry_ff, fwd_entry_in;
   logic signed [VALUE_W-1:0]  hrp_ff, hrp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_item_type               rsp_item_ff, rsp_item_in;

   hold_entry_type             entry;
   logic                       cur_valid;
   logic                       upd;
   logic                       commit;
   logic signed [VALUE_W-1:0]  hv;
   logic signed [VALUE_W-1:0]  hrp_new;

   always_comb begin
      // A write-back to the address read in the same cycle is forwarded.
      entry     = fwd_hit_ff ? fwd_entry_ff : rd_entry;
      cur_valid = entry.tag == s1_item.epoch;
      upd       = s1_item.en && s1_item.finite &&
                  (!cur_valid || ($signed(s1_item.value) > $signed(entry.value)));
      hv        = upd ? s1_item.value : (cur_valid ? entry.value : VALUE_MIN);
      hrp_new   = (s1_item.en && ($signed(hv) > $signed(hrp_ff))) ? hv : hrp_ff;

      adv       = !rsp_valid_ff || !rsp_stall;
      commit    = s1_valid && adv;

      wr_en          = commit && upd;
      wr_addr        = s1_addr;
      wr_entry.tag   = s1_item.epoch;
      wr_entry.value = s1_item.value;

      fwd_hit_in   = fwd_hit_ff;
      fwd_entry_in = fwd_entry_ff;
      if (accept) begin
         fwd_hit_in   = wr_en && (wr_addr == rd_addr);
         fwd_entry_in = wr_entry;
      end

      hrp_in = hrp_ff;
      if (restart) begin
         hrp_in = VALUE_MIN;
      end else if (commit) begin
         hrp_in = s1_item.group_done ? VALUE_MIN : hrp_new;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (commit && s1_item.group_done) begin
         rsp_valid_in              = 1'b1;
         rsp_item_in.display_index = s1_item.shown;
         rsp_item_in.live_peak     = s1_item.live;
         rsp_item_in.hold_peak     = s1_item.en ? hrp_new : VALUE_MIN;
         rsp_item_in.last          = s1_item.frame_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff   <= 1'b0;
         hrp_ff       <= VALUE_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_hit_ff   <= fwd_hit_in;
         hrp_ff       <= hrp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fwd_entry_ff <= fwd_entry_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== design/spectrum_max_hold_peak_pool_unit.sv =====
// ----------------------------------------------------------------------------
// spectrum_max_hold_peak_pool_unit: spectrum max-hold with peak decimation
// Keeps a per-bin max-hold store and pools bins into display groups, giving
// the live peak and the held peak of every group.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle, in bin order, unless input is held
// off, and gives one result item at the end of each display group, its last
// bin being registered in the framing stage and then in the output register.
// Each bin passes a framing stage, which reads the bin's hold store entry, and
// a peak stage, which merges it and writes it back; a write that meets a read
// of the same entry is forwarded, so bins of a one-bin frame also stream at
// full rate. A result waiting in the output register does not stop input until
// the pipeline behind it is full. Clear items give no result: every store
// entry carries an 8-bit clear generation tag and a clear only moves the
// current generation on. When the generations run out (after 254 clears,
// counting the clears caused by a change of frame size) and once after reset,
// the store is swept one entry per cycle. The sweep holds off input while it
// runs or waits to start; when the last generation was taken by a bin's change
// of frame size, it starts only once that bin has left the framing stage, later
// while that bin waits behind a stalled result; configuration writes are taken
// at any time. Configuration is written while the unit is idle; a write of
// frame_bins or display_bins restarts the frame at bin zero.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_max_hold_peak_pool_unit #(
   parameter int MAX_BINS = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  smhpp_pkg::req_item_type                 req_item,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output smhpp_pkg::rsp_item_type                 rsp_item,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [smhpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [smhpp_pkg::CFG_W-1:0]        csr_wdata
);
   import smhpp_pkg::*;

   localparam int AW = $clog2(MAX_BINS);
   localparam int SW = $clog2(MAX_BINS + 1);
   localparam int CW = (SW > CFG_W) ? SW : CFG_W;

   // Register values of zero act as one, values above MAX_BINS as MAX_BINS.
   function automatic logic [SW-1:0] eff_size(input logic [CFG_W-1:0] raw);
      logic [CW-1:0] wide;
      logic [SW-1:0] res;
      wide = CW'(raw);
      if (wide == '0) begin
         res = SW'(1);
      end else if (wide > CW'(MAX_BINS)) begin
         res = SW'(MAX_BINS);
      end else begin
         res = SW'(wide);
      end
      return res;
   endfunction

   logic [CFG_W-1:0]   frame_bins_ff, frame_bins_in;
   logic [CFG_W-1:0]   display_bins_ff, display_bins_in;
   logic               maxhold_enable_ff, maxhold_enable_in;

   logic               cfg_write;
   logic               restart;
   logic [SW-1:0]      f_eff;
   logic [SW-1:0]      d_eff;

   logic               adv;
   logic               scrub_busy;
   logic               accept;
   logic               accept_bin;
   logic               accept_clr;
   logic               size_clear;
   logic               clear_req;
   logic [EPOCH_W-1:0] epoch_cur;

   logic [AW-1:0]      frame_rd_addr;
   logic               s1_valid;
   stage_item_type     s1_item;
   logic [AW-1:0]      s1_addr;

   logic               scrub_rd_en;
   logic [AW-1:0]      scrub_rd_addr;
   logic               scrub_wr_en;
   logic [AW-1:0]      scrub_wr_addr;
   hold_entry_type     scrub_wr_entry;

   logic               peak_wr_en;
   logic [AW-1:0]      peak_wr_addr;
   hold_entry_type     peak_wr_entry;

   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   hold_entry_type     ram_wr_entry;
   hold_entry_type     ram_rd_entry;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;
   assign restart   = cfg_write &&
                      ((csr_index == CSR_FRAME_BINS) || (csr_index == CSR_DISPLAY_BINS));

   always_comb begin
      frame_bins_in     = frame_bins_ff;
      display_bins_in   = display_bins_ff;
      maxhold_enable_in = maxhold_enable_ff;
      if (cfg_write) begin
         case (csr_index)
            CSR_FRAME_BINS:     frame_bins_in     = csr_wdata;
            CSR_DISPLAY_BINS:   display_bins_in   = csr_wdata;
            CSR_MAXHOLD_ENABLE: maxhold_enable_in = csr_wdata[0];
            default: begin
               // Indexes past the register list are ignored.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bins_ff     <= FRAME_BINS_RESET;
         display_bins_ff   <= DISPLAY_BINS_RESET;
         maxhold_enable_ff <= 1'b0;
      end else begin
         frame_bins_ff     <= frame_bins_in;
         display_bins_ff   <= display_bins_in;
         maxhold_enable_ff <= maxhold_enable_in;
      end
   end

   assign f_eff = eff_size(frame_bins_ff);
   assign d_eff = eff_size(display_bins_ff);

   // Input is held off while a bin waits in the peak stage behind a stalled
   // result, and while the store is being swept or waits for a sweep.
   assign req_stall  = (s1_valid && !adv) || scrub_busy;
   assign accept     = req_valid && !req_stall;
   assign accept_bin = accept && (req_item.op == OP_BIN);
   assign accept_clr = accept && (req_item.op == OP_CLEAR);

   // A clear item, or the first enabled bin after a change of frame size,
   // starts a new clear generation.
   assign clear_req  = accept_clr || size_clear;

   smhpp_framer #(
      .MAX_BINS (MAX_BINS)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .accept     (accept_bin),
      .adv        (adv),
      .value      (req_item.bin_value),
      .finite     (req_item.bin_finite),
      .en         (maxhold_enable_ff),
      .f_eff      (f_eff),
      .d_eff      (d_eff),
      .item_epoch (epoch_cur),
      .rd_addr    (frame_rd_addr),
      .size_clear (size_clear),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .s1_addr    (s1_addr)
   );

   smhpp_scrubber #(
      .MAX_BINS (MAX_BINS)
   ) u_scrubber (
      .clock     (clock),
      .reset     (reset),
      .clear_req (clear_req),
      .start_ok  (!s1_valid),
      .rd_entry  (ram_rd_entry),
      .epoch_cur (epoch_cur),
      .busy      (scrub_busy),
      .rd_en     (scrub_rd_en),
      .rd_addr   (scrub_rd_addr),
      .wr_en     (scrub_wr_en),
      .wr_addr   (scrub_wr_addr),
      .wr_entry  (scrub_wr_entry)
   );

   smhpp_peak_stage #(
      .MAX_BINS (MAX_BINS)
   ) u_peak_stage (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .accept    (accept_bin),
      .rd_addr   (frame_rd_addr),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .s1_addr   (s1_addr),
      .rd_entry  (ram_rd_entry),
      .rsp_stall (rsp_stall),
      .adv       (adv),
      .wr_en     (peak_wr_en),
      .wr_addr   (peak_wr_addr),
      .wr_entry  (peak_wr_entry),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // The sweep owns the store ports only while no bin is in flight.
   assign ram_rd_en    = accept_bin || scrub_rd_en;
   assign ram_rd_addr  = scrub_rd_en ? scrub_rd_addr : frame_rd_addr;
   assign ram_wr_en    = peak_wr_en || scrub_wr_en;
   assign ram_wr_addr  = scrub_wr_en ? scrub_wr_addr : peak_wr_addr;
   assign ram_wr_entry = scrub_wr_en ? scrub_wr_entry : peak_wr_entry;

   smhpp_hold_ram #(
      .DEPTH (MAX_BINS)
   ) u_hold_ram (
      .clock    (clock),
      .rd_en    (ram_rd_en),
      .rd_addr  (ram_rd_addr),
      .rd_entry (ram_rd_entry),
      .wr_en    (ram_wr_en),
      .wr_addr  (ram_wr_addr),
      .wr_entry (ram_wr_entry)
   );

   // No bin may be in the peak stage while the sweep uses the store.
   a_sweep_alone: assert property (@(posedge clock) disable iff (reset)
      (scrub_rd_en || scrub_wr_en) |-> !s1_valid)
      else $error("store sweep overlaps a bin in flight");

   // The sweep and the bin write-back never write in the same cycle.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(scrub_wr_en && peak_wr_en))
      else $error("two writers on the hold store");

endmodule

`default_nettype wire

// ===== dv/spectrum_max_hold_peak_pool_unit_tb.sv =====
// ----------------------------------------------------------------------------
// spectrum_max_hold_peak_pool_unit_tb: self-checking bench for the peak pool
// Streams spectrum bins and clear items through the unit under a range of
// frame and display geometries, predicts every pooled display bin and
// compares the results field by field as they leave the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_max_hold_peak_pool_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import smhpp_pkg::*;

   localparam int MAX_BINS     = 4096;
   // Idle time for the pipe after the last predicted result has come out.
   localparam int DRAIN_CYCLES = 8;
   // Longest quiet spell allowed: it must cover the store sweep after reset or
   // after the clear generations run out, and the long receiver hold-off.
   localparam int QUIET_LIMIT  = 20000;
   localparam int LONG_HOLD    = 600;

   // The fourth register index is not decoded by the unit.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {GAPS_NONE, GAPS_LIGHT, GAPS_HEAVY} gap_mode_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_item_type           req_item;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_item_type           rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   spectrum_max_hold_peak_pool_unit #(
      .MAX_BINS (MAX_BINS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // -------------------------------------------------------------------------
   // Predicted state of the unit. The hold store is kept as a value and a
   // seen flag per bin; an entry never seen reads as the most negative value.
   // -------------------------------------------------------------------------
   logic signed [VALUE_W-1:0] hold_value [MAX_BINS];
   bit                        hold_seen  [MAX_BINS];
   int unsigned               frame_pos;
   int unsigned               group_pos;
   int unsigned               group_last_bin;
   logic signed [VALUE_W-1:0] live_max;
   logic signed [VALUE_W-1:0] hold_max;
   int unsigned               hold_frame_size;
   logic [CFG_W-1:0]          reg_frame;
   logic [CFG_W-1:0]          reg_display;
   bit                        reg_hold_en;

   // Items waiting to be offered, and pooled display bins still to arrive.
   req_item_type              bins_to_send [$];
   rsp_item_type              expected_groups [$];

   int                        mismatches;
   int                        quiet_cycles;
   bit                        req_fire;

   // Sender and receiver idling controls, set by the sequence per phase.
   gap_mode_type              gap_mode;
   stall_mode_type            stall_mode;
   int                        burst_left;
   int                        gap_left;
   bit                        want_long_hold;
   bit                        long_hold_done;
   int                        hold_cycles;
   int unsigned               stall_tick;

   // A register value of zero behaves as one bin, and anything above the
   // store depth behaves as the full depth.
   function automatic int unsigned bins_in_use(input logic [CFG_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_BINS) return MAX_BINS;
      return int'(raw);
   endfunction

   // One past the last bin of display group g. With no more bins than groups
   // every bin is its own group.
   function automatic int unsigned group_limit(input int unsigned g, input int unsigned f,
                                               input int unsigned d);
      longint unsigned span;
      if (f <= d) return g + 1;
      span = (longint'(g) + 1) * longint'(f);
      return int'(span / longint'(d));
   endfunction

   task automatic restart_frame();
      frame_pos      = 0;
      group_pos      = 0;
      group_last_bin = group_limit(0, bins_in_use(reg_frame), bins_in_use(reg_display));
      live_max       = VALUE_MIN;
      hold_max       = VALUE_MIN;
   endtask

   task automatic wipe_hold_store();
      for (int i = 0; i < MAX_BINS; i++) hold_seen[i] = 1'b0;
   endtask

   // Predictor: takes one accepted item and queues the display bin it
   // completes, if any.
   task automatic pool_bin(input req_item_type it);
      int unsigned               f;
      int unsigned               d;
      int unsigned               idx;
      logic signed [VALUE_W-1:0] held;
      bit                        group_done;
      bit                        frame_done;
      rsp_item_type              group;
      f = bins_in_use(reg_frame);
      d = bins_in_use(reg_display);
      if (it.op == OP_CLEAR) begin
         // A clear drops every held value but leaves the framing alone.
         wipe_hold_store();
      end else begin
         if (frame_pos >= f) restart_frame();
         idx = frame_pos;
         if (reg_hold_en) begin
            // A change of frame size invalidates the whole store first.
            if (hold_frame_size != f) begin
               wipe_hold_store();
               hold_frame_size = f;
            end
            // Non-finite bins never reach the store.
            if (it.bin_finite && (!hold_seen[idx] || it.bin_value > hold_value[idx])) begin
               hold_value[idx] = it.bin_value;
               hold_seen[idx]  = 1'b1;
            end
            held = hold_seen[idx] ? hold_value[idx] : VALUE_MIN;
            if (held > hold_max) hold_max = held;
         end
         // Every bin, finite or not, takes part in the live peak.
         if (it.bin_value > live_max) live_max = it.bin_value;

         frame_done = (idx + 1 == f);
         if (f <= d) begin
            group_done          = 1'b1;
            group.display_index = DISP_W'(idx);
         end else begin
            group_done          = (idx + 1 >= group_last_bin) || frame_done;
            group.display_index = DISP_W'(group_pos);
         end
         frame_pos = idx + 1;

         if (group_done) begin
            group.live_peak = live_max;
            group.hold_peak = reg_hold_en ? hold_max : VALUE_MIN;
            group.last      = frame_done;
            expected_groups.push_back(group);
            if (frame_done) begin
               restart_frame();
            end else begin
               live_max       = VALUE_MIN;
               hold_max       = VALUE_MIN;
               group_pos      = group_pos + 1;
               group_last_bin = group_limit(group_pos, f, d);
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Rising edge: everything that handshakes is seen here, before the unit's
   // own updates of the same edge take effect.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) pool_bin(req_item);

      // Register writes update the predicted configuration. A geometry
      // write starts the frame again from bin zero.
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_BINS: begin
               reg_frame = csr_wdata;
               restart_frame();
            end
            CSR_DISPLAY_BINS: begin
               reg_display = csr_wdata;
               restart_frame();
            end
            CSR_MAXHOLD_ENABLE: begin
               reg_hold_en = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      // Result monitor: each display bin against the oldest prediction.
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_groups.size() == 0) begin
            $error("unexpected display bin: index %0d live %0d hold %0d last %0d",
                   rsp_item.display_index, rsp_item.live_peak, rsp_item.hold_peak,
                   rsp_item.last);
            mismatches++;
         end else begin
            rsp_item_type want;
            want = expected_groups.pop_front();
            if (rsp_item.display_index !== want.display_index) begin
               $error("display_index: expected %0d, actual %0d",
                      want.display_index, rsp_item.display_index);
               mismatches++;
            end
            if (rsp_item.live_peak !== want.live_peak) begin
               $error("live_peak: expected %0d, actual %0d",
                      want.live_peak, rsp_item.live_peak);
               mismatches++;
            end
            if (rsp_item.hold_peak !== want.hold_peak) begin
               $error("hold_peak: expected %0d, actual %0d",
                      want.hold_peak, rsp_item.hold_peak);
               mismatches++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_item.last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: any handshake counts as progress.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("spectrum_max_hold_peak_pool_unit_tb NOT OK");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sender: offers the queued items in bursts of random length with random
   // gaps in between. An item that is stalled is held unchanged.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bins_to_send.size() != 0) begin
            req_item  <= bins_to_send.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               case (gap_mode)
                  GAPS_LIGHT: gap_left = $urandom_range(0, 3);
                  GAPS_HEAVY: gap_left = $urandom_range(2, 15);
                  default:    gap_left = 0;
               endcase
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stalls according to the phase's pattern. Once asked, it holds
   // off for a long stretch so that the unit fills up and stalls its input.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      stall_tick++;
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (want_long_hold && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_cycles    = LONG_HOLD - 1;
         rsp_stall      <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PATTERN: rsp_stall <= ((stall_tick % 7) < 3);
            STALL_HEAVY:   rsp_stall <= ($urandom_range(0, 3) != 0);
            default:       rsp_stall <= 1'b0;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Sequence helpers.
   // -------------------------------------------------------------------------
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes all three registers; the upper bits of the enable word are noise.
   task automatic configure(input logic [CFG_W-1:0] frame, input logic [CFG_W-1:0] display,
                            input bit en, input gap_mode_type gaps,
                            input stall_mode_type stalls);
      write_register(CSR_FRAME_BINS, frame);
      write_register(CSR_DISPLAY_BINS, display);
      write_register(CSR_MAXHOLD_ENABLE, {12'($urandom()), en});
      gap_mode   = gaps;
      stall_mode = stalls;
   endtask

   task automatic push_item(input logic op, input logic signed [VALUE_W-1:0] value,
                            input logic finite);
      req_item_type it;
      it.op         = op;
      it.bin_value  = value;
      it.bin_finite = finite;
      bins_to_send.push_back(it);
   endtask

   // Waits until everything queued has been taken and every predicted bin
   // has come out, then gives bins without a result time to clear the pipe.
   task automatic drain();
      @(posedge clock);
      while (bins_to_send.size() != 0 || req_valid || expected_groups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random item: mostly values scattered around a per-phase level, so that
   // held values are beaten now and then, with some full-range values,
   // extremes, non-finite bins and a few clears.
   function automatic req_item_type random_bin(input logic signed [VALUE_W-1:0] centre);
      req_item_type it;
      int unsigned  pick;
      pick          = $urandom_range(0, 99);
      it.op         = (pick < 3) ? OP_CLEAR : OP_BIN;
      it.bin_finite = ($urandom_range(0, 7) != 0);
      if (pick < 30)
         it.bin_value = 16'($urandom());
      else if (pick < 36)
         it.bin_value = pick[0] ? 16'sh7FFF : VALUE_MIN;
      else
         it.bin_value = centre + 16'($urandom_range(0, 511)) - 16'sd256;
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      logic signed [VALUE_W-1:0] centre;
      logic [CFG_W-1:0]          frame;
      logic [CFG_W-1:0]          display;

      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_item       = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_FRAME_BINS;
      csr_wdata      = '0;
      mismatches     = 0;
      quiet_cycles   = 0;
      req_fire       = 1'b0;
      gap_mode       = GAPS_NONE;
      stall_mode     = STALL_NONE;
      burst_left     = 0;
      gap_left       = 0;
      want_long_hold = 1'b0;
      long_hold_done = 1'b0;
      hold_cycles    = 0;
      stall_tick     = 0;

      // Predicted state after reset.
      reg_frame       = FRAME_BINS_RESET;
      reg_display     = DISPLAY_BINS_RESET;
      reg_hold_en     = 1'b0;
      hold_frame_size = 0;
      wipe_hold_store();
      restart_frame();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a four-bin frame in two groups of two. The extremes of the
      // value range, a non-finite bin that still sets the live peak, then a
      // clear so that the next frame's held peaks start again from scratch.
      configure(13'd4, 13'd2, 1'b1, GAPS_LIGHT, STALL_RANDOM);
      push_item(OP_BIN, 16'sh7FFF, 1'b1);
      push_item(OP_BIN, VALUE_MIN, 1'b1);
      push_item(OP_BIN, 16'sd100, 1'b0);
      push_item(OP_BIN, -16'sd5, 1'b1);
      push_item(OP_CLEAR, 16'sh1234, 1'b1);
      push_item(OP_BIN, VALUE_MIN, 1'b0);
      push_item(OP_BIN, 16'sd1, 1'b1);
      push_item(OP_BIN, -16'sd1, 1'b1);
      push_item(OP_BIN, 16'sd200, 1'b1);
      drain();

      // Zero in both geometry registers acts as one: a one-bin frame passed
      // straight through, and the change of frame size empties the store.
      configure(13'd0, 13'd0, 1'b1, GAPS_NONE, STALL_NONE);
      push_item(OP_BIN, 16'sd7, 1'b1);
      push_item(OP_BIN, 16'sd3, 1'b1);
      push_item(OP_BIN, 16'sd9, 1'b0);
      drain();

      // The spare register index must change nothing; then sizes above the
      // store depth, with the hold disabled so that its peak stays at minimum.
      write_register(CSR_SPARE, 13'h1FFF);
      configure(13'h1FFF, 13'h1FFF, 1'b0, GAPS_LIGHT, STALL_PATTERN);
      push_item(OP_BIN, VALUE_MIN, 1'b1);
      push_item(OP_BIN, 16'sh7FFF, 1'b0);
      push_item(OP_BIN, 16'sd12, 1'b1);
      drain();

      // Five bins in groups of two and three. The enable is switched off in
      // the middle of a group, so that group reports no held peak, and on
      // again for the next frame, which finds the earlier held values.
      configure(13'd5, 13'd2, 1'b1, GAPS_NONE, STALL_RANDOM);
      push_item(OP_BIN, 16'sd50, 1'b1);
      push_item(OP_BIN, 16'sd60, 1'b1);
      push_item(OP_BIN, 16'sd70, 1'b1);
      drain();
      write_register(CSR_MAXHOLD_ENABLE, 13'h1FFE);
      push_item(OP_BIN, 16'sd80, 1'b1);
      push_item(OP_BIN, -16'sd90, 1'b1);
      drain();
      write_register(CSR_MAXHOLD_ENABLE, 13'd1);
      push_item(OP_BIN, -16'sd10, 1'b1);
      push_item(OP_BIN, -16'sd20, 1'b0);
      push_item(OP_BIN, -16'sd30, 1'b1);
      push_item(OP_BIN, 16'sd40, 1'b1);
      push_item(OP_BIN, VALUE_MIN, 1'b1);
      drain();

      // Random: a short pass-through frame repeated many times builds up a
      // deep hold store. The receiver holds off at length here while the
      // sender keeps offering, so the unit backs up to its input.
      configure(13'd16, 13'd16, 1'b1, GAPS_NONE, STALL_RANDOM);
      centre = 16'($urandom());
      repeat (350) bins_to_send.push_back(random_bin(centre));
      want_long_hold = 1'b1;
      drain();

      // Same frame size with the hold disabled, then enabled again: the store
      // must survive both the pause and the geometry rewrite.
      configure(13'd16, 13'd16, 1'b0, GAPS_LIGHT, STALL_PATTERN);
      repeat (60) bins_to_send.push_back(random_bin(centre));
      drain();
      configure(13'd16, 13'd16, 1'b1, GAPS_HEAVY, STALL_NONE);
      repeat (60) bins_to_send.push_back(random_bin(centre));
      drain();

      // Uneven pooling, groups of differing width.
      configure(13'd37, 13'd5, 1'b1, GAPS_LIGHT, STALL_HEAVY);
      centre = 16'($urandom());
      repeat (250) bins_to_send.push_back(random_bin(centre));
      drain();

      configure(13'd100, 13'd3, 1'b1, GAPS_HEAVY, STALL_RANDOM);
      repeat (200) bins_to_send.push_back(random_bin(centre));
      drain();

      // Full-depth frames, only partly streamed: one group for the whole
      // frame, then one bin per group.
      configure(13'd4096, 13'd1, 1'b1, GAPS_NONE, STALL_PATTERN);
      repeat (120) bins_to_send.push_back(random_bin(centre));
      drain();
      configure(13'd4096, 13'd4096, 1'b1, GAPS_LIGHT, STALL_RANDOM);
      repeat (150) bins_to_send.push_back(random_bin(centre));
      drain();

      // One bin per frame against the largest display size.
      configure(13'd1, 13'd4096, 1'b1, GAPS_HEAVY, STALL_HEAVY);
      repeat (100) bins_to_send.push_back(random_bin(centre));
      drain();

      // Oversized frame register against one group fewer than bins.
      configure(13'd5000, 13'd4095, 1'b0, GAPS_NONE, STALL_NONE);
      repeat (100) bins_to_send.push_back(random_bin(centre));
      drain();

      // Random small geometries, including the out-of-range register values.
      for (int k = 0; k < 8; k++) begin
         frame   = (k == 3) ? 13'd0 : 13'($urandom_range(1, 48));
         display = (k == 5) ? 13'h1FFF : 13'($urandom_range(1, 48));
         configure(frame, display, ($urandom_range(0, 3) != 0),
                   gap_mode_type'($urandom_range(0, 2)),
                   stall_mode_type'($urandom_range(0, 3)));
         centre = 16'($urandom());
         repeat (60) bins_to_send.push_back(random_bin(centre));
         drain();
      end

      if (mismatches == 0)
         $display("spectrum_max_hold_peak_pool_unit_tb OK");
      else
         $display("spectrum_max_hold_peak_pool_unit_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
